/* src/button_gesture_detector_defines.svh */
// assertion helpers used by the checker file
`ifndef BUTTON_GESTURE_DETECTOR_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BGD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgd assertion failed");

// next-cycle implication, disabled while reset is low
`define BGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgd assertion failed");

`endif

/* src/bgd_pkg.sv */
// ----------------------------------------------------------------------------
// bgd_pkg
// Types and constants of the button gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE            = 3'd0,
        ST_PRESSED         = 3'd1,
        ST_CLICKED         = 3'd2,
        ST_CLICKED_PRESSED = 3'd3,
        ST_DOUBLE_CLICKED  = 3'd4,
        ST_RELEASE_WAIT    = 3'd5
    } t_state;

    typedef enum logic [2:0] {
        EV_CHANGED         = 3'd0,
        EV_PRESS           = 3'd1,
        EV_RELEASE         = 3'd2,
        EV_PRESSED         = 3'd3,
        EV_CLICKED         = 3'd4,
        EV_CLICKED_PRESSED = 3'd5,
        EV_DOUBLE_CLICKED  = 3'd6,
        EV_RELEASED        = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        REG_DEBOUNCE      = 2'd0,
        REG_HOLD          = 2'd1,
        REG_CLICK         = 2'd2,
        REG_PRESSED_LEVEL = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_event ev;
        logic   last;
    } t_ev_entry;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [15:0] HOLD_RESET     = 16'd300;
    localparam logic [15:0] CLICK_RESET    = 16'd250;

    // event reported when a deadline runs out in the given state
    function automatic t_event state_event(input t_state st);
        t_event ev;
        ev = EV_PRESSED;
        unique case (st)
            ST_PRESSED:         ev = EV_PRESSED;
            ST_CLICKED:         ev = EV_CLICKED;
            ST_CLICKED_PRESSED: ev = EV_CLICKED_PRESSED;
            ST_DOUBLE_CLICKED:  ev = EV_DOUBLE_CLICKED;
            ST_RELEASE_WAIT:    ev = EV_RELEASED;
            default:            ev = EV_PRESSED;
        endcase
        return ev;
    endfunction

endpackage

`default_nettype wire

/* src/button_gesture_detector.sv */
// A tick is taken when i_valid and o_ready are high; its events are registered in the queue.
// A tick yields up to three events, drained one per cycle while i_ready is high from a four-entry queue.
// Throughput: one tick per cycle while the queue holds at most one event.
// A tick that leaves more than one event queued holds o_ready low until the queue drains to one.
// Reset (synchronous, active low) restores register defaults, idle state, empty queue.
// ----------------------------------------------------------------------------
// button_gesture_detector
// Debounces a sampled button level and reports click, double click and hold.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_detector #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_level,
    // event channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_event_res,
    output logic             o_last,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [TIMER_BITS-1:0] TMAX = '1;
    localparam int QDEPTH = 4;
    localparam int QPTR   = $clog2(QDEPTH);
    localparam int QCNT   = $clog2(QDEPTH + 1);

    // configuration
    logic [15:0] r_debounce;
    logic [15:0] r_hold;
    logic [15:0] r_click;
    logic        r_pressed_level;

    // gesture state
    bgd_pkg::t_state       r_state, n_state;
    logic                  r_deb, n_deb;
    logic                  r_lat, n_lat;
    logic                  r_prev;
    logic [TIMER_BITS-1:0] r_ela, n_ela;
    logic [TIMER_BITS-1:0] r_dl, n_dl;
    logic                  r_armed, n_armed;

    // event queue
    bgd_pkg::t_ev_entry r_q [QDEPTH];
    logic [QPTR-1:0]    r_wr, r_rd;
    logic [QCNT-1:0]    r_count;

    bgd_pkg::t_event ev [3];
    logic [1:0]      ev_cnt;
    logic            cur, latp, accept, pop;

    function automatic logic [TIMER_BITS-1:0] clamp(input logic [15:0] ticks);
        logic [31:0] t32;
        t32 = {16'd0, ticks};
        if (t32 > 32'(TMAX)) begin
            return TMAX;
        end
        return TIMER_BITS'(t32);
    endfunction

    assign pready  = 1'b1;
    assign o_ready = (r_count <= QCNT'(1));
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_event_res = r_q[r_rd].ev;
    assign o_last      = r_q[r_rd].last;

    always_comb begin
        unique case (bgd_pkg::t_reg_idx'(paddr[3:2]))
            bgd_pkg::REG_DEBOUNCE:      prdata = {16'd0, r_debounce};
            bgd_pkg::REG_HOLD:          prdata = {16'd0, r_hold};
            bgd_pkg::REG_CLICK:         prdata = {16'd0, r_click};
            bgd_pkg::REG_PRESSED_LEVEL: prdata = {31'd0, r_pressed_level};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce      <= bgd_pkg::DEBOUNCE_RESET;
            r_hold          <= bgd_pkg::HOLD_RESET;
            r_click         <= bgd_pkg::CLICK_RESET;
            r_pressed_level <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (bgd_pkg::t_reg_idx'(paddr[3:2]))
                bgd_pkg::REG_DEBOUNCE:      r_debounce      <= pwdata[15:0];
                bgd_pkg::REG_HOLD:          r_hold          <= pwdata[15:0];
                bgd_pkg::REG_CLICK:         r_click         <= pwdata[15:0];
                bgd_pkg::REG_PRESSED_LEVEL: r_pressed_level <= pwdata[0];
                default:                    r_pressed_level <= r_pressed_level;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_deb   = r_deb;
        n_lat   = r_lat;
        n_ela   = r_ela;
        n_dl    = r_dl;
        n_armed = r_armed;
        ev      = '{default: bgd_pkg::EV_CHANGED};
        ev_cnt  = 2'd0;
        cur     = (i_level == r_pressed_level);
        latp    = (r_lat == r_pressed_level);

        // timeout first
        if (r_armed) begin
            if (r_ela != TMAX) begin
                n_ela = r_ela + TIMER_BITS'(1);
            end
            if (n_ela >= r_dl) begin
                n_armed = 1'b0;
                if (r_deb) begin
                    n_deb = 1'b0;
                    unique case (r_state)
                        bgd_pkg::ST_IDLE: begin
                            if (latp && cur) begin
                                n_state = bgd_pkg::ST_PRESSED;
                                ev[0] = bgd_pkg::EV_PRESS;
                                ev_cnt = 2'd1;
                                n_dl = clamp(r_hold);
                                n_armed = 1'b1;
                            end else if (latp) begin
                                n_state = bgd_pkg::ST_CLICKED;
                                ev[0] = bgd_pkg::EV_PRESS;
                                ev[1] = bgd_pkg::EV_RELEASE;
                                ev_cnt = 2'd2;
                                n_dl = clamp(r_click);
                                n_armed = 1'b1;
                            end
                        end
                        bgd_pkg::ST_PRESSED: begin
                            if (!cur) begin
                                n_state = bgd_pkg::ST_CLICKED;
                                ev[0] = bgd_pkg::EV_RELEASE;
                                ev_cnt = 2'd1;
                                n_dl = clamp(r_click);
                                n_armed = 1'b1;
                            end else if (!latp) begin
                                n_state = bgd_pkg::ST_CLICKED_PRESSED;
                                ev[0] = bgd_pkg::EV_RELEASE;
                                ev[1] = bgd_pkg::EV_PRESS;
                                ev_cnt = 2'd2;
                                n_dl = clamp(r_hold);
                                n_armed = 1'b1;
                            end else begin
                                n_state = bgd_pkg::ST_IDLE;
                            end
                        end
                        bgd_pkg::ST_CLICKED: begin
                            if (cur) begin
                                n_state = bgd_pkg::ST_CLICKED_PRESSED;
                                ev[0] = bgd_pkg::EV_PRESS;
                                ev_cnt = 2'd1;
                                n_dl = clamp(r_hold);
                                n_armed = 1'b1;
                            end else if (latp) begin
                                n_state = bgd_pkg::ST_DOUBLE_CLICKED;
                                ev[0] = bgd_pkg::EV_PRESS;
                                ev[1] = bgd_pkg::EV_RELEASE;
                                ev_cnt = 2'd2;
                                n_dl = clamp(r_click);
                                n_armed = 1'b1;
                            end else begin
                                n_state = bgd_pkg::ST_IDLE;
                            end
                        end
                        bgd_pkg::ST_CLICKED_PRESSED: begin
                            if (!cur) begin
                                n_state = bgd_pkg::ST_IDLE;
                                ev[0] = bgd_pkg::EV_RELEASE;
                                ev[1] = bgd_pkg::EV_DOUBLE_CLICKED;
                                ev_cnt = 2'd2;
                            end else begin
                                n_state = bgd_pkg::ST_RELEASE_WAIT;
                                ev[0] = bgd_pkg::EV_CLICKED_PRESSED;
                                ev_cnt = 2'd1;
                            end
                        end
                        default: begin
                            ev[0] = bgd_pkg::state_event(r_state);
                            ev_cnt = 2'd1;
                            n_state = bgd_pkg::ST_IDLE;
                        end
                    endcase
                end else begin
                    if (r_state != bgd_pkg::ST_IDLE) begin
                        ev[0] = bgd_pkg::state_event(r_state);
                        ev_cnt = 2'd1;
                    end
                    if (r_state == bgd_pkg::ST_PRESSED
                            || r_state == bgd_pkg::ST_CLICKED_PRESSED) begin
                        n_state = bgd_pkg::ST_RELEASE_WAIT;
                    end else begin
                        n_state = bgd_pkg::ST_IDLE;
                    end
                end
            end
        end

        // edge outside a debounce window opens one
        if (!n_deb && (i_level != r_prev)) begin
            n_deb   = 1'b1;
            n_lat   = i_level;
            n_ela   = '0;
            n_dl    = clamp(r_debounce);
            n_armed = 1'b1;
            ev[ev_cnt] = bgd_pkg::EV_CHANGED;
            ev_cnt  = ev_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgd_pkg::ST_IDLE;
            r_deb   <= 1'b0;
            r_lat   <= 1'b1;
            r_prev  <= 1'b1;
            r_ela   <= '0;
            r_dl    <= '0;
            r_armed <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
            r_deb   <= n_deb;
            r_lat   <= n_lat;
            r_prev  <= i_level;
            r_ela   <= n_ela;
            r_dl    <= n_dl;
            r_armed <= n_armed;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_wr <= r_wr + QPTR'(ev_cnt);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR'(1);
            end
            r_count <= r_count + (accept ? QCNT'(ev_cnt) : QCNT'(0))
                       - (pop ? QCNT'(1) : QCNT'(0));
        end
    end

    // queue payload, last flag on the final event of the tick
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < ev_cnt) begin
                    r_q[r_wr + QPTR'(k)] <= '{ev: ev[k], last: (2'(k) == ev_cnt - 2'd1)};
                end
            end
        end
    end

endmodule

`default_nettype wire

/* src/bgd_checker.sv */
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks of the button gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_gesture_detector_defines.svh"

module bgd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [2:0] o_event_res,
    input wire logic       o_last
);

    // a stalled event holds
    `BGD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_event_res) && $stable(o_last))

    // an empty queue always takes a tick
    `BGD_ASSERT_NOW(a_idle_ready, i_clk, i_rst_n, !o_valid, o_ready)

    // a changed event is always the final one of its tick
    `BGD_ASSERT_NOW(a_changed_last, i_clk, i_rst_n,
        o_valid && (o_event_res == bgd_pkg::EV_CHANGED), o_last)

    // a press that is not last is followed at once by a release or a change
    `BGD_ASSERT_NEXT(a_press_follow, i_clk, i_rst_n,
        o_valid && i_ready && !o_last && (o_event_res == bgd_pkg::EV_PRESS),
        o_valid && ((o_event_res == bgd_pkg::EV_RELEASE)
            || (o_event_res == bgd_pkg::EV_CHANGED)))

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_event_res (o_event_res),
    .o_last      (o_last)
);

`default_nettype wire
